// File: sv/bphd_pkg.sv
package bphd_pkg;

   // Number of buttons and their placement in the raw vector.
   localparam int BUTTON_COUNT = 5;
   localparam int UPDOWN_COUNT = 2;

   // Counter and limit width.
   localparam int CNT_W = 16;

   // Signal code width and packed result width.
   localparam int SIG_W = 2;
   localparam int RESULT_W = BUTTON_COUNT * SIG_W;

   // Stream word widths, rounded up to whole bytes.
   localparam int REQ_DATA_W = ((BUTTON_COUNT + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((RESULT_W + 7) / 8) * 8;

   // Register file addressing.
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = CNT_W;

   localparam logic [CNT_W-1:0] UPDOWN_HOLD_RESET = CNT_W'(1000);
   localparam logic [CNT_W-1:0] PRESET_HOLD_RESET = CNT_W'(2000);
   localparam logic [CNT_W-1:0] DEBOUNCE_RESET = CNT_W'(50);

   // Per-button signal codes.
   typedef enum logic [SIG_W-1:0] {
      SIG_RELEASED = 2'd0,
      SIG_PUSHED   = 2'd1,
      SIG_HOLD     = 2'd2
   } sig_type;

   // Register indexes.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_UPDOWN_HOLD = 2'd0,
      CSR_PRESET_HOLD = 2'd1,
      CSR_DEBOUNCE    = 2'd2
   } csr_addr_type;

   // Controls fed to one button lane for one tick.
   typedef struct packed {
      logic             step;
      logic             raw_any;
      logic             raw_bit;
      logic             lone;
      logic             preset;
      logic [CNT_W-1:0] hold_limit;
      logic [CNT_W-1:0] debounce_limit;
   } lane_ctl_type;

   // Status returned by one button lane.
   typedef struct packed {
      logic    mark;
      sig_type sig;
      sig_type sig_next;
   } lane_stat_type;

endpackage

// File: sv/button_push_hold_debouncer.sv
// Channel  Direction  tdata fields (low bit up)                    tuser
// req      in         raw_buttons[4:0], zero pad to 8 bits          none
// rsp      out        up, down, preset1, preset2, preset3 (2 each)  none
// csr      in         write enable, 2-bit index, 16-bit data        none
//
// One word is taken per clock while req_tready is high; its result is registered.
// All five button lanes update in parallel in the accept cycle, each with its own counters.
// A skid stage holds a second result, so req_tready drops only when both output words wait.
// Reset is synchronous and active high; it restores the default limits and clears all lanes.
module button_push_hold_debouncer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bphd_pkg::REQ_DATA_W-1:0]   req_tdata,  // [4:0] raw_buttons
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bphd_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [1:0] up, [3:2] down,
                                                         // [5:4] preset1, [7:6] preset2,
                                                         // [9:8] preset3
   input  logic                              csr_we,
   input  logic [bphd_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [bphd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [bphd_pkg::CNT_W-1:0]        updown_hold_ff, preset_hold_ff, debounce_ff;
   logic [bphd_pkg::BUTTON_COUNT-1:0] raw;
   logic [bphd_pkg::BUTTON_COUNT-1:0] marks;
   logic [bphd_pkg::RESULT_W-1:0]     result;
   logic [bphd_pkg::BUTTON_COUNT-1:0] pushed_now;
   logic                              accept;
   logic                              full;
   bphd_pkg::lane_ctl_type            ctl  [bphd_pkg::BUTTON_COUNT];
   bphd_pkg::lane_stat_type           stat [bphd_pkg::BUTTON_COUNT];

   // Limit registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         updown_hold_ff <= bphd_pkg::UPDOWN_HOLD_RESET;
         preset_hold_ff <= bphd_pkg::PRESET_HOLD_RESET;
         debounce_ff    <= bphd_pkg::DEBOUNCE_RESET;
      end else if (csr_we) begin
         unique case (bphd_pkg::csr_addr_type'(csr_addr))
            bphd_pkg::CSR_UPDOWN_HOLD: updown_hold_ff <= csr_wdata;
            bphd_pkg::CSR_PRESET_HOLD: preset_hold_ff <= csr_wdata;
            bphd_pkg::CSR_DEBOUNCE:    debounce_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = ~full;
   assign accept     = req_tvalid & req_tready;
   assign raw        = req_tdata[bphd_pkg::BUTTON_COUNT-1:0];

   // One lane per button; a lane counts a release only when its mark is the only one set.
   for (genvar b = 0; b < bphd_pkg::BUTTON_COUNT; b++) begin : g_lane
      assign ctl[b].step    = accept;
      assign ctl[b].raw_any = |raw;
      assign ctl[b].raw_bit = raw[b];
      assign ctl[b].lone    = (marks == (bphd_pkg::BUTTON_COUNT'(1) << b));
      assign ctl[b].preset  = (b >= bphd_pkg::UPDOWN_COUNT);
      assign ctl[b].hold_limit =
         (b < bphd_pkg::UPDOWN_COUNT) ? updown_hold_ff : preset_hold_ff;
      assign ctl[b].debounce_limit = debounce_ff;

      bphd_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl[b]),
         .stat  (stat[b])
      );

      assign marks[b]      = stat[b].mark;
      assign pushed_now[b] = (stat[b].sig == bphd_pkg::SIG_PUSHED);
      assign result[b*bphd_pkg::SIG_W +: bphd_pkg::SIG_W] = stat[b].sig_next;
   end

   // Gather the lane signals into the result word.
   bphd_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (result),
      .full       (full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   // An idle tick releases every button but a lone one, so at most one shows pushed.
   a_one_pushed: assert property (@(posedge clock) disable iff (reset)
      $countones(pushed_now) <= 1)
      else $error("more than one button signals pushed");

   // A tick with buttons down never sets a mark for a button that is up.
   a_marks_follow_raw: assert property (@(posedge clock) disable iff (reset)
      (accept && (raw != '0)) |=> ((marks & ~($past(marks) | $past(raw))) == '0))
      else $error("mark set for a button that was not pressed");
`endif

endmodule

// File: sv/bphd_lane.sv
module bphd_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  bphd_pkg::lane_ctl_type ctl,
   output bphd_pkg::lane_stat_type stat
);

   logic                       mark_ff, mark_in;
   logic [bphd_pkg::CNT_W-1:0] hold_ff, hold_in;
   logic [bphd_pkg::CNT_W-1:0] rel_ff, rel_in;
   bphd_pkg::sig_type          sig_ff, sig_in;
   logic [bphd_pkg::CNT_W-1:0] hold_inc;
   logic [bphd_pkg::CNT_W-1:0] rel_inc;

   assign hold_inc = hold_ff + bphd_pkg::CNT_W'(1);
   assign rel_inc  = rel_ff + bphd_pkg::CNT_W'(1);

   // One tick of the button's press, hold and release tracking.
   always_comb begin
      mark_in = mark_ff;
      hold_in = hold_ff;
      rel_in  = rel_ff;
      sig_in  = sig_ff;
      if (ctl.step) begin
         if (ctl.raw_any) begin
            if (ctl.raw_bit) begin
               if (hold_inc > ctl.hold_limit) begin
                  sig_in  = bphd_pkg::SIG_HOLD;
                  mark_in = 1'b0;
                  hold_in = '0;
               end else begin
                  mark_in = 1'b1;
                  hold_in = hold_inc;
               end
            end
         end else if (ctl.lone) begin
            if (rel_inc > ctl.debounce_limit) begin
               sig_in  = bphd_pkg::SIG_PUSHED;
               mark_in = 1'b0;
               hold_in = '0;
               rel_in  = '0;
            end else begin
               rel_in = rel_inc;
            end
         end else begin
            sig_in = bphd_pkg::SIG_RELEASED;
            if (ctl.preset) begin
               hold_in = '0;
            end
         end
      end
   end

   // Lane state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= 1'b0;
         hold_ff <= '0;
         rel_ff  <= '0;
         sig_ff  <= bphd_pkg::SIG_RELEASED;
      end else begin
         mark_ff <= mark_in;
         hold_ff <= hold_in;
         rel_ff  <= rel_in;
         sig_ff  <= sig_in;
      end
   end

   assign stat.mark     = mark_ff;
   assign stat.sig      = sig_ff;
   assign stat.sig_next = sig_in;

endmodule

// File: sv/bphd_merge.sv
module bphd_merge (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic [bphd_pkg::RESULT_W-1:0]     push_data,
   output logic                              full,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bphd_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   logic                          main_valid_ff, main_valid_in;
   logic                          skid_valid_ff, skid_valid_in;
   logic [bphd_pkg::RESULT_W-1:0] main_ff, main_in;
   logic [bphd_pkg::RESULT_W-1:0] skid_ff, skid_in;
   logic                          pop;

   assign pop = main_valid_ff & rsp_tready;

   // Output word with a skid stage behind it; a push only arrives when the skid is empty.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = 1'b0;
         end
      end
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload words.
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full       = skid_valid_ff;
   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = bphd_pkg::RSP_DATA_W'(main_ff);

`ifndef NO_ASSERTIONS
   // The skid stage only fills behind a waiting output word.
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid word held without an output word");
`endif

endmodule

// File: tb/tb_button_push_hold_debouncer.sv
`timescale 1ns / 100ps

module tb_button_push_hold_debouncer;

   localparam int CLK_HALF = 5;
   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_REPORTS = 10;
   // Index past the last register; writes to it must change nothing.
   localparam logic [bphd_pkg::CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;

   // Tracks the five button lanes and checks every result word against them.
   class button_signal_board;
      logic [bphd_pkg::CNT_W-1:0] updown_hold;
      logic [bphd_pkg::CNT_W-1:0] preset_hold;
      logic [bphd_pkg::CNT_W-1:0] debounce;
      logic [bphd_pkg::BUTTON_COUNT-1:0] marks;
      logic [bphd_pkg::CNT_W-1:0] hold_cnt[bphd_pkg::BUTTON_COUNT];
      logic [bphd_pkg::CNT_W-1:0] release_cnt[bphd_pkg::BUTTON_COUNT];
      bphd_pkg::sig_type lane_sig[bphd_pkg::BUTTON_COUNT];
      logic [bphd_pkg::RSP_DATA_W-1:0] expected_words[$];
      int mismatches;
      string lane_name[bphd_pkg::BUTTON_COUNT];

      function new();
         updown_hold = bphd_pkg::UPDOWN_HOLD_RESET;
         preset_hold = bphd_pkg::PRESET_HOLD_RESET;
         debounce = bphd_pkg::DEBOUNCE_RESET;
         marks = '0;
         for (int b = 0; b < bphd_pkg::BUTTON_COUNT; b++) begin
            hold_cnt[b] = '0;
            release_cnt[b] = '0;
            lane_sig[b] = bphd_pkg::SIG_RELEASED;
         end
         mismatches = 0;
         lane_name = '{"up", "down", "preset1", "preset2", "preset3"};
      endfunction

      function void set_limit(logic [bphd_pkg::CSR_ADDR_W-1:0] idx,
                              logic [bphd_pkg::CNT_W-1:0] val);
         case (idx)
            bphd_pkg::CSR_UPDOWN_HOLD: updown_hold = val;
            bphd_pkg::CSR_PRESET_HOLD: preset_hold = val;
            bphd_pkg::CSR_DEBOUNCE:    debounce = val;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // One accepted tick: advance every lane and queue the resulting word.
      function void note_tick(logic [bphd_pkg::BUTTON_COUNT-1:0] raw);
         logic [bphd_pkg::CNT_W-1:0] limit;
         logic [bphd_pkg::RSP_DATA_W-1:0] word;
         if (raw != '0) begin
            for (int b = 0; b < bphd_pkg::BUTTON_COUNT; b++) begin
               if (raw[b]) begin
                  limit = (b < bphd_pkg::UPDOWN_COUNT) ? updown_hold : preset_hold;
                  marks[b] = 1'b1;
                  hold_cnt[b] = hold_cnt[b] + 1'b1;
                  if (hold_cnt[b] > limit) begin
                     lane_sig[b] = bphd_pkg::SIG_HOLD;
                     marks[b] = 1'b0;
                     hold_cnt[b] = '0;
                  end
               end
            end
         end else begin
            // Only a lane whose mark stands alone counts toward a push.
            for (int b = 0; b < bphd_pkg::BUTTON_COUNT; b++) begin
               if (marks == (bphd_pkg::BUTTON_COUNT'(1) << b)) begin
                  release_cnt[b] = release_cnt[b] + 1'b1;
                  if (release_cnt[b] > debounce) begin
                     lane_sig[b] = bphd_pkg::SIG_PUSHED;
                     release_cnt[b] = '0;
                     hold_cnt[b] = '0;
                     marks[b] = 1'b0;
                  end
               end else begin
                  lane_sig[b] = bphd_pkg::SIG_RELEASED;
                  if (b >= bphd_pkg::UPDOWN_COUNT) begin
                     hold_cnt[b] = '0;
                  end
               end
            end
         end
         word = '0;
         for (int b = 0; b < bphd_pkg::BUTTON_COUNT; b++) begin
            word[b*bphd_pkg::SIG_W +: bphd_pkg::SIG_W] = lane_sig[b];
         end
         expected_words.push_back(word);
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("%s", msg);
         end
      endfunction

      // Compare one result word, lane by lane, with the oldest expected word, and check that its pad bits are zero.
      function void check_signals(logic [bphd_pkg::RSP_DATA_W-1:0] word);
         logic [bphd_pkg::RSP_DATA_W-1:0] exp_word;
         if (expected_words.size() == 0) begin
            report($sformatf("Unexpected result word %h", word));
            return;
         end
         exp_word = expected_words.pop_front();
         for (int b = 0; b < bphd_pkg::BUTTON_COUNT; b++) begin
            if (word[b*bphd_pkg::SIG_W +: bphd_pkg::SIG_W] !==
                exp_word[b*bphd_pkg::SIG_W +: bphd_pkg::SIG_W]) begin
               report($sformatf("Mismatch on %s: expected %0d, got %0d", lane_name[b],
                                exp_word[b*bphd_pkg::SIG_W +: bphd_pkg::SIG_W],
                                word[b*bphd_pkg::SIG_W +: bphd_pkg::SIG_W]));
            end
         end
         if (word[bphd_pkg::RSP_DATA_W-1:bphd_pkg::RESULT_W] !== '0) begin
            report($sformatf("Nonzero pad bits: expected 0, got %h",
                             word[bphd_pkg::RSP_DATA_W-1:bphd_pkg::RESULT_W]));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [bphd_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [bphd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [bphd_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [bphd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   bit src_idle_en = 1'b0;
   bit sink_idle_en = 1'b0;
   bit hold_off_req = 1'b0;
   int cycle_count = 0;
   button_signal_board signal_board;

   button_push_hold_debouncer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #CLK_HALF clock = ~clock;

   // Guard against a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Check every result word taken from the block.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         signal_board.check_signals(rsp_tdata);
      end
   end

   // Result side: random stalls, plus one long hold-off when requested.
   initial begin : sink_ctl
      int stall;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(1, 14);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one tick word and wait until the block takes it.
   task automatic send_tick(input logic [bphd_pkg::BUTTON_COUNT-1:0] raw);
      int gap;
      @(negedge clock);
      if (src_idle_en && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= bphd_pkg::REQ_DATA_W'(raw);
      do @(posedge clock); while (!req_tready);
      signal_board.note_tick(raw);
   endtask

   task automatic send_run(input logic [bphd_pkg::BUTTON_COUNT-1:0] raw, input int count);
      repeat (count) send_tick(raw);
   endtask

   // Stop offering and wait for every outstanding result word.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (signal_board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [bphd_pkg::CSR_ADDR_W-1:0] idx,
                              input logic [bphd_pkg::CNT_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      signal_board.set_limit(idx, val);
   endtask

   // Press lengths reach a little past a limit, capped for huge limits.
   function automatic int span_of(input int lim);
      return (lim > 36) ? 40 : lim + 3;
   endfunction

   // Mostly press-then-release sequences, with some random noise words.
   task automatic random_ticks(input int count, input bit mid_pause);
      int sent;
      int kind;
      int plen;
      int rlen;
      int btn;
      logic [bphd_pkg::BUTTON_COUNT-1:0] mask;
      bit paused;
      sent = 0;
      paused = 1'b0;
      while (sent < count) begin
         if (mid_pause && !paused && sent >= count / 2) begin
            drain();
            paused = 1'b1;
         end
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            if (kind < 5) begin
               btn = $urandom_range(0, bphd_pkg::BUTTON_COUNT - 1);
               mask = bphd_pkg::BUTTON_COUNT'(1) << btn;
            end else begin
               btn = $urandom_range(0, bphd_pkg::BUTTON_COUNT - 1);
               mask = bphd_pkg::BUTTON_COUNT'($urandom_range(1, 31));
            end
            plen = $urandom_range(1, span_of(btn < bphd_pkg::UPDOWN_COUNT ?
                                             int'(signal_board.updown_hold) :
                                             int'(signal_board.preset_hold)));
            rlen = $urandom_range(1, span_of(int'(signal_board.debounce)));
            send_run(mask, plen);
            send_run('0, rlen);
            sent += plen + rlen;
         end else begin
            plen = $urandom_range(1, 6);
            repeat (plen) send_tick(bphd_pkg::BUTTON_COUNT'($urandom_range(0, 31)));
            sent += plen;
         end
      end
   endtask

   // One setting of the three limits followed by random traffic.
   task automatic run_phase(input logic [bphd_pkg::CNT_W-1:0] ud,
                            input logic [bphd_pkg::CNT_W-1:0] pr,
                            input logic [bphd_pkg::CNT_W-1:0] db, input int count,
                            input bit src_en, input bit sink_en,
                            input bit long_hold, input bit mid_pause);
      drain();
      write_limit(bphd_pkg::CSR_UPDOWN_HOLD, ud);
      write_limit(bphd_pkg::CSR_PRESET_HOLD, pr);
      write_limit(bphd_pkg::CSR_DEBOUNCE, db);
      src_idle_en = src_en;
      sink_idle_en = sink_en;
      hold_off_req = long_hold;
      random_ticks(count, mid_pause);
   endtask

   initial begin : main
      logic [bphd_pkg::BUTTON_COUNT-1:0] directed[25];
      signal_board = new();
      directed = '{5'd0, 5'd31, 5'd0, 5'd2, 5'd2, 5'd1, 5'd1, 5'd28, 5'd28, 5'd28,
                   5'd28, 5'd16, 5'd0, 5'd0, 5'd1, 5'd0, 5'd0, 5'd3, 5'd0, 5'd0,
                   5'd2, 5'd2, 5'd0, 5'd0, 5'd0};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset limits: a short up press is pushed after the default debounce.
      src_idle_en = 1'b1;
      sink_idle_en = 1'b1;
      send_run(5'b00001, 3);
      send_run('0, 53);

      // Directed ticks with tight limits; the spare index must be ignored.
      drain();
      write_limit(bphd_pkg::CSR_UPDOWN_HOLD, 16'd2);
      write_limit(bphd_pkg::CSR_PRESET_HOLD, 16'd3);
      write_limit(bphd_pkg::CSR_DEBOUNCE, 16'd1);
      write_limit(CSR_SPARE, 16'd0);
      foreach (directed[i]) send_tick(directed[i]);

      // Random phases over a spread of limits, extremes included.
      run_phase(16'd0, 16'd0, 16'd0, 150, 1'b1, 1'b1, 1'b0, 1'b0);
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 100, 1'b1, 1'b0, 1'b1, 1'b0);
      run_phase(16'd4, 16'd6, 16'd2, 400, 1'b1, 1'b1, 1'b0, 1'b0);
      run_phase(16'd10, 16'd15, 16'd5, 400, 1'b0, 1'b1, 1'b0, 1'b0);
      run_phase(16'd1, 16'd2, 16'd0, 300, 1'b1, 1'b1, 1'b0, 1'b1);
      run_phase(16'd7, 16'd3, 16'd8, 300, 1'b1, 1'b0, 1'b0, 1'b0);
      run_phase(16'd5, 16'd9, 16'd3, 250, 1'b0, 1'b0, 1'b0, 1'b0);
      drain();

      if (signal_board.mismatches == 0 && signal_board.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
